// File: sv/rngr_pkg.sv
// Package for the ring neighbor grant with aging block.
// Holds field widths, reset values, state encodings and the cell structs.
// No dependencies; every other file imports it.
package rngr_pkg;

   localparam int MAX_SEATS_DEF = 16;
   localparam int SEAT_W        = 4;
   localparam int STAMP_W       = 32;
   localparam int SEAT_CNT_W    = 5;
   localparam int AGING_W       = 16;
   localparam int CSR_DATA_W    = 16;
   localparam int AGING_FACTOR  = 5;
   // threshold 5 * aging_unit fits in 19 bits
   localparam int THR_W         = 19;

   localparam logic [SEAT_CNT_W-1:0] SEAT_CNT_RST = 5'd5;
   localparam logic [THR_W-1:0]      THR_RST      = 19'd5;

   localparam logic CSR_SEAT_COUNT = 1'b0;
   localparam logic CSR_AGING_UNIT = 1'b1;

   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      SEAT_THINKING = 2'd0,
      SEAT_HUNGRY   = 2'd1,
      SEAT_EATING   = 2'd2
   } seat_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_EVAL_FIRST,
      ST_EVAL_SECOND,
      ST_SEND
   } ctrl_state_type;

   // what a cell shows its two neighbors
   typedef struct packed {
      seat_state_type     state;
      logic [STAMP_W-1:0] stamp;
      logic               aged;
   } cell_view_type;

   // broadcast write command; each cell has its own enable
   typedef struct packed {
      seat_state_type     state;
      logic               load_stamp;
      logic [STAMP_W-1:0] stamp;
   } cell_wr_type;

endpackage

// File: sv/rngr_req_if.sv
// Input channel of the ring neighbor grant block: valid/ready plus one item.
// Depends on rngr_pkg for field widths.
interface rngr_req_if import rngr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [SEAT_W-1:0]  seat;
   logic [STAMP_W-1:0] now;

   modport source (output valid, output operation, output seat, output now, input ready);
   modport sink   (input valid, input operation, input seat, input now, output ready);
endinterface

// File: sv/rngr_rsp_if.sv
// Result channel of the ring neighbor grant block: valid/ready plus one grant.
// Depends on rngr_pkg for field widths.
interface rngr_rsp_if import rngr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SEAT_W-1:0] granted_seat;
   logic              last;

   modport source (output valid, output granted_seat, output last, input ready);
   modport sink   (input valid, input granted_seat, input last, output ready);
endinterface

// File: sv/rngr_cell.sv
// One seat of the ring: holds its state and hunger stamp, shows them to
// its neighbors and judges its own grant from theirs. Depends on rngr_pkg.
module rngr_cell import rngr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  cell_wr_type        wr,
   input  cell_view_type      left_nb,
   input  cell_view_type      right_nb,
   input  logic [STAMP_W-1:0] now,
   input  logic [THR_W-1:0]   thr,
   output cell_view_type      view,
   output logic               may_eat
);

   seat_state_type     state_ff, state_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [STAMP_W:0]   waited;
   logic               aged;
   logic               block_l, block_r;

   always_comb begin
      state_in = state_ff;
      stamp_in = stamp_ff;
      if (wr_en) begin
         state_in = wr.state;
         if (wr.load_stamp) begin
            stamp_in = wr.stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEAT_THINKING;
      end else begin
         state_ff <= state_in;
      end
   end

   // stamp only matters once the seat is hungry, which always reloads it
   always_ff @(posedge clock) begin
      stamp_ff <= stamp_in;
   end

   // time going backwards counts as zero wait
   assign waited = {1'b0, now} - {1'b0, stamp_ff};
   assign aged   = (state_ff == SEAT_HUNGRY) &&
                   (waited[STAMP_W] ? (thr == '0)
                                    : (waited[STAMP_W-1:0] >= STAMP_W'(thr)));

   assign view = '{state: state_ff, stamp: stamp_ff, aged: aged};

   assign block_l = left_nb.aged  && (left_nb.stamp  < stamp_ff);
   assign block_r = right_nb.aged && (right_nb.stamp < stamp_ff);

   assign may_eat = (state_ff == SEAT_HUNGRY) &&
                    (left_nb.state  != SEAT_EATING) &&
                    (right_nb.state != SEAT_EATING) &&
                    !block_l && !block_r;

endmodule

// File: sv/ring_neighbor_grant_with_aging_core.sv
// Ring neighbor grant with aging: top level, a ring of rngr_cell seats and
// a small sequencer. Depends on rngr_pkg, rngr_req_if, rngr_rsp_if, rngr_cell.
// Steps: a request is accepted in idle, written to its seat, then judged; a
// release is judged for its left and then its right neighbor. Grants are sent
// once judging ends, subject to output stall. One item at a time: a new item
// is taken only in idle; an item whose seat lies outside the ring is dropped.
// Reset (synchronous): all seats thinking, seat_count 5, aging_unit 1.
module ring_neighbor_grant_with_aging_core import rngr_pkg::*; #(
   parameter int MAX_SEATS = MAX_SEATS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   rngr_req_if.sink              req_chan,
   rngr_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int IDX_W = $clog2(MAX_SEATS);
   localparam int CNT_W = $clog2(MAX_SEATS + 1);
   localparam int CMP_W = (CNT_W > SEAT_CNT_W) ? CNT_W : SEAT_CNT_W;

   // configuration; hold the aging threshold pre-multiplied by five
   logic [SEAT_CNT_W-1:0] seat_cnt_ff;
   logic [THR_W-1:0]      thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seat_cnt_ff <= SEAT_CNT_RST;
         thr_ff      <= THR_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SEAT_COUNT: seat_cnt_ff <= csr_data[SEAT_CNT_W-1:0];
            CSR_AGING_UNIT: thr_ff <= {1'b0, csr_data, 2'b00} + THR_W'(csr_data);
            default: ;
         endcase
      end
   end

   // clamp the ring size to [2, MAX_SEATS]; the register keeps its bits
   logic [CMP_W-1:0] cnt_wide;
   logic [CNT_W-1:0] cnt_eff;
   logic [IDX_W-1:0] last_idx;

   always_comb begin
      cnt_wide = CMP_W'(seat_cnt_ff);
      if (cnt_wide < CMP_W'(2)) begin
         cnt_eff = CNT_W'(2);
      end else if (cnt_wide > CMP_W'(MAX_SEATS)) begin
         cnt_eff = CNT_W'(MAX_SEATS);
      end else begin
         cnt_eff = CNT_W'(cnt_wide);
      end
   end

   assign last_idx = IDX_W'(cnt_eff - CNT_W'(1));

   // item registers
   ctrl_state_type     ctrl_ff, ctrl_in;
   logic               op_ff;
   logic [IDX_W-1:0]   seat_ff;
   logic [STAMP_W-1:0] now_ff;

   logic req_take, in_range;
   assign req_chan.ready = (ctrl_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign in_range       = CMP_W'(req_chan.seat) < CMP_W'(cnt_eff);

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff   <= req_chan.operation;
         seat_ff <= IDX_W'(req_chan.seat);
         now_ff  <= req_chan.now;
      end
   end

   // ring neighbors of the item's seat
   logic [IDX_W-1:0] left_idx, right_idx, eval_tgt;
   assign left_idx  = (seat_ff == '0) ? last_idx : seat_ff - IDX_W'(1);
   assign right_idx = (seat_ff == last_idx) ? '0 : seat_ff + IDX_W'(1);

   // chain of cells
   cell_view_type        cell_view [MAX_SEATS];
   logic [MAX_SEATS-1:0] may_eat;
   logic [MAX_SEATS-1:0] cell_wr_en;
   cell_wr_type          cell_wr;
   logic                 grant;

   for (genvar i = 0; i < MAX_SEATS; i++) begin : g_cell
      cell_view_type left_nb, right_nb;

      // wrap the ring at the effective seat count
      if (i == 0) begin : g_left_wrap
         assign left_nb = cell_view[last_idx];
      end else begin : g_left
         assign left_nb = cell_view[i-1];
      end

      if (i == MAX_SEATS - 1) begin : g_right_end
         assign right_nb = cell_view[0];
      end else begin : g_right
         assign right_nb = (last_idx == IDX_W'(i)) ? cell_view[0] : cell_view[i+1];
      end

      assign cell_wr_en[i] = ((ctrl_ff == ST_WRITE) && (seat_ff == IDX_W'(i))) ||
                             (grant && (eval_tgt == IDX_W'(i)));

      rngr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (cell_wr_en[i]),
         .wr       (cell_wr),
         .left_nb  (left_nb),
         .right_nb (right_nb),
         .now      (now_ff),
         .thr      (thr_ff),
         .view     (cell_view[i]),
         .may_eat  (may_eat[i])
      );
   end

   // result buffer: up to two grants, sent once the item is fully judged
   logic [IDX_W-1:0] res_seat_ff [2];
   logic [1:0]       res_n_ff;
   logic             rd_ptr_ff;
   logic             send_take, send_last;

   assign send_take = rsp_chan.valid && rsp_chan.ready;
   assign send_last = ({1'b0, rd_ptr_ff} == (res_n_ff - 2'd1));

   // next state
   always_comb begin
      ctrl_in = ctrl_ff;
      case (ctrl_ff)
         ST_IDLE: begin
            // drop items whose seat lies outside the ring
            if (req_take && in_range) ctrl_in = ST_WRITE;
         end
         ST_WRITE: ctrl_in = ST_EVAL_FIRST;
         ST_EVAL_FIRST: begin
            if (op_ff == OP_RELEASE) ctrl_in = ST_EVAL_SECOND;
            else if (grant)          ctrl_in = ST_SEND;
            else                     ctrl_in = ST_IDLE;
         end
         ST_EVAL_SECOND: begin
            if (grant || (res_n_ff != 2'd0)) ctrl_in = ST_SEND;
            else                              ctrl_in = ST_IDLE;
         end
         ST_SEND: begin
            if (send_take && send_last) ctrl_in = ST_IDLE;
         end
         default: ctrl_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      eval_tgt = seat_ff;
      grant    = 1'b0;
      cell_wr  = '{state: SEAT_EATING, load_stamp: 1'b0, stamp: now_ff};
      case (ctrl_ff)
         ST_WRITE: begin
            // request: hungry and stamped; release: thinking, stamp kept
            cell_wr.state      = (op_ff == OP_RELEASE) ? SEAT_THINKING : SEAT_HUNGRY;
            cell_wr.load_stamp = (op_ff == OP_REQUEST);
         end
         ST_EVAL_FIRST: begin
            // a release checks the left neighbor first
            eval_tgt = (op_ff == OP_RELEASE) ? left_idx : seat_ff;
            grant    = may_eat[eval_tgt];
         end
         ST_EVAL_SECOND: begin
            eval_tgt = right_idx;
            grant    = may_eat[eval_tgt];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff   <= ST_IDLE;
         res_n_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
      end else begin
         ctrl_ff <= ctrl_in;
         if (ctrl_ff == ST_WRITE) begin
            res_n_ff  <= 2'd0;
            rd_ptr_ff <= 1'b0;
         end else if (grant) begin
            res_n_ff <= res_n_ff + 2'd1;
         end else if (send_take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (grant) begin
         res_seat_ff[res_n_ff[0]] <= eval_tgt;
      end
   end

   assign rsp_chan.valid        = (ctrl_ff == ST_SEND);
   assign rsp_chan.granted_seat = SEAT_W'(res_seat_ff[rd_ptr_ff]);
   assign rsp_chan.last         = send_last;

   // a grant is only shown while the buffer holds one
   a_send_has_result: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (res_n_ff != 2'd0) && (res_n_ff <= 2'd2))
      else $error("result shown with empty buffer");

   // the seat being reported must be eating
   a_granted_eats: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (cell_view[res_seat_ff[rd_ptr_ff]].state == SEAT_EATING))
      else $error("granted seat is not eating");

   // only a release checks a second neighbor
   a_second_is_release: assert property (@(posedge clock) disable iff (reset)
      (ctrl_ff == ST_EVAL_SECOND) |-> (op_ff == OP_RELEASE) && $past(ctrl_ff == ST_EVAL_FIRST))
      else $error("second check outside a release");

endmodule
